>>> hw/rtl/lfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcs_pkg - shared constants for the led flicker color shader
// register map, easing and flicker limits, and the constant divisors used by
// the bit-serial division steps
// ----------------------------------------------------------------------------
package lfcs_pkg;

    // register map (index = paddr[2])
    localparam logic       REG_MIN_LEVEL  = 1'b0;
    localparam logic       REG_MAX_LEVEL  = 1'b1;
    localparam int         APB_ADDR_W     = 3;

    localparam logic [7:0] MIN_LEVEL_RST  = 8'd10;
    localparam logic [7:0] MAX_LEVEL_RST  = 8'd255;

    // easing and flicker
    localparam logic [7:0] EASE_STEP      = 8'd2;
    localparam logic [7:0] FLICKER_LOW    = 8'd80;
    localparam logic [7:0] FLICKER_HIGH   = 8'd139;

    // color weights: red (200-c)/200, green 7/10, blue (100+3c)/400
    localparam logic [7:0] WARM_SPAN      = 8'd200;
    localparam logic [9:0] BLUE_BASE      = 10'd100;
    localparam logic [3:0] GREEN_WEIGHT   = 4'd7;

    // divisors, sized to the trial remainder of each division step
    localparam logic [7:0] DIV_SCALE      = 8'd100;
    localparam logic [8:0] DIV_RED        = 9'd200;
    localparam logic [4:0] DIV_GREEN      = 5'd10;
    localparam logic [9:0] DIV_BLUE       = 10'd400;

    localparam logic [9:0] CHANNEL_MAX    = 10'd255;

endpackage

>>> hw/rtl/led_flicker_color_shader_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_flicker_color_shader_top - per-pixel led flicker and color shading
// eases a stored brightness level toward a target on frame start, scales it
// by a flicker percent and splits it into red, green and blue channels
// ----------------------------------------------------------------------------
// pixels are taken one at a time: s_tready is high only while the sequencer is
// idle, so a new pixel waits until the bit-serial chain has handed its result over
//   (msb-first multiply, 9-step divide by 100, 10-step three-lane divide)
// a finished result waits in the output register while the next pixel runs
// reset (aresetn low, synchronous): level 0, min_level 10, max_level 255,
//   engine idle, no output pending
// ----------------------------------------------------------------------------
module led_flicker_color_shader_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input pixel stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // target_level, warmth_percent, flicker
    input  logic                            s_tuser,   // frame_start
    // shaded pixel stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // red, green, blue, strip_level
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lfcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // sequencer phases
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;   // level * flicker, msb first
    localparam logic [2:0] ST_DIV1 = 3'd2;   // /100, quotient bits feed weight products
    localparam logic [2:0] ST_DIV2 = 3'd3;   // three channel divisions side by side
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [3:0] MUL_LAST  = 4'd7;
    localparam logic [3:0] DIV1_LAST = 4'd8;
    localparam logic [3:0] DIV2_LAST = 4'd9;

    // control
    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  level_reg, level_next;
    logic [7:0]  min_level_reg, max_level_reg;
    logic        m_tvalid_reg, m_tvalid_next;

    // datapath
    logic [7:0]  f_reg, f_next;            // clamped flicker, shifted out msb first
    logic [7:0]  wr_reg, wr_next;          // red weight 200-c
    logic [9:0]  wb_reg, wb_next;          // blue weight 100+3c
    logic        red_zero_reg, red_zero_next;
    logic [7:0]  strip_reg, strip_next;
    logic [15:0] accp_reg, accp_next;      // level * flicker
    logic [6:0]  rem1_reg, rem1_next;
    logic [8:0]  num1_reg, num1_next;
    logic [16:0] accr_reg, accr_next;      // low 10 bits become red quotient
    logic [11:0] accg_reg, accg_next;
    logic [18:0] accb_reg, accb_next;
    logic [7:0]  remr_reg, remr_next;
    logic [3:0]  remg_reg, remg_next;
    logic [8:0]  remb_reg, remb_next;
    logic [31:0] out_reg, out_next;

    // input fields
    logic [7:0]  in_target, in_warmth, in_flicker;
    assign in_target  = s_tdata[7:0];
    assign in_warmth  = s_tdata[15:8];
    assign in_flicker = s_tdata[23:16];

    // easing step, strip clamp on the eased level and flicker clamp
    logic [8:0]  lvl_up;
    logic [7:0]  up_val, lvl_dn, dn_val, eased, strip_val, f_clamp;
    always_comb begin
        lvl_up = {1'b0, level_reg} + {1'b0, lfcs_pkg::EASE_STEP};
        up_val = (lvl_up > {1'b0, in_target}) ? in_target : lvl_up[7:0];
        lvl_dn = (level_reg >= lfcs_pkg::EASE_STEP) ? (level_reg - lfcs_pkg::EASE_STEP)
                                                     : 8'd0;
        dn_val = (lvl_dn < in_target) ? in_target : lvl_dn;
        if (!s_tuser) begin
            eased = level_reg;
        end else if (level_reg < in_target) begin
            eased = up_val;
        end else if (level_reg > in_target) begin
            eased = dn_val;
        end else begin
            eased = level_reg;
        end
        // zero stays zero; the min test wins over the max test
        if (eased == 8'd0) begin
            strip_val = 8'd0;
        end else if (eased < min_level_reg) begin
            strip_val = min_level_reg;
        end else if (eased > max_level_reg) begin
            strip_val = max_level_reg;
        end else begin
            strip_val = eased;
        end
        if (in_flicker < lfcs_pkg::FLICKER_LOW) begin
            f_clamp = lfcs_pkg::FLICKER_LOW;
        end else if (in_flicker > lfcs_pkg::FLICKER_HIGH) begin
            f_clamp = lfcs_pkg::FLICKER_HIGH;
        end else begin
            f_clamp = in_flicker;
        end
    end

    // division step trials
    logic [7:0]  trial1;
    logic        q1;
    logic [8:0]  trialr;
    logic [4:0]  trialg;
    logic [9:0]  trialb;
    logic        qr, qg, qb;
    assign trial1 = {rem1_reg, num1_reg[8]};
    assign q1     = (trial1 >= lfcs_pkg::DIV_SCALE);
    assign trialr = {remr_reg, accr_reg[9]};
    assign trialg = {remg_reg, accg_reg[9]};
    assign trialb = {remb_reg, accb_reg[9]};
    assign qr     = (trialr >= lfcs_pkg::DIV_RED);
    assign qg     = (trialg >= lfcs_pkg::DIV_GREEN);
    assign qb     = (trialb >= lfcs_pkg::DIV_BLUE);

    // saturated channels from the finished quotients
    logic [7:0]  red_sat, green_sat, blue_sat;
    always_comb begin
        if (red_zero_reg) begin
            red_sat = 8'd0;
        end else if (accr_reg[9:0] > lfcs_pkg::CHANNEL_MAX) begin
            red_sat = lfcs_pkg::CHANNEL_MAX[7:0];
        end else begin
            red_sat = accr_reg[7:0];
        end
        green_sat = (accg_reg[9:0] > lfcs_pkg::CHANNEL_MAX) ? lfcs_pkg::CHANNEL_MAX[7:0]
                                                            : accg_reg[7:0];
        blue_sat  = (accb_reg[9:0] > lfcs_pkg::CHANNEL_MAX) ? lfcs_pkg::CHANNEL_MAX[7:0]
                                                            : accb_reg[7:0];
    end

    // sequencer and datapath next state
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        level_next    = level_reg;
        m_tvalid_next = m_tvalid_reg;
        f_next        = f_reg;
        wr_next       = wr_reg;
        wb_next       = wb_reg;
        red_zero_next = red_zero_reg;
        strip_next    = strip_reg;
        accp_next     = accp_reg;
        rem1_next     = rem1_reg;
        num1_next     = num1_reg;
        accr_next     = accr_reg;
        accg_next     = accg_reg;
        accb_next     = accb_reg;
        remr_next     = remr_reg;
        remg_next     = remg_reg;
        remb_next     = remb_reg;
        out_next      = out_reg;

        // a pending result leaves on its transaction
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    level_next    = eased;
                    strip_next    = strip_val;
                    f_next        = f_clamp;
                    red_zero_next = (in_warmth >= lfcs_pkg::WARM_SPAN);
                    wr_next       = lfcs_pkg::WARM_SPAN - in_warmth;
                    wb_next       = lfcs_pkg::BLUE_BASE + {1'b0, in_warmth, 1'b0}
                                    + {2'b00, in_warmth};
                    accp_next     = 16'd0;
                    accr_next     = 17'd0;
                    accg_next     = 12'd0;
                    accb_next     = 19'd0;
                    cnt_next      = MUL_LAST;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                // horner form: one flicker bit per cycle
                accp_next = {accp_reg[14:0], 1'b0} + (f_reg[7] ? {8'd0, level_reg} : 16'd0);
                f_next    = {f_reg[6:0], 1'b0};
                if (cnt_reg == 4'd0) begin
                    // product < 100 * 512, so the top bits start below the divisor
                    rem1_next  = accp_next[15:9];
                    num1_next  = accp_next[8:0];
                    cnt_next   = DIV1_LAST;
                    state_next = ST_DIV1;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_DIV1: begin
                rem1_next = q1 ? 7'(trial1 - lfcs_pkg::DIV_SCALE) : trial1[6:0];
                num1_next = {num1_reg[7:0], 1'b0};
                // scaled level bits arrive msb first and go straight into the weights
                accr_next = {accr_reg[15:0], 1'b0} + (q1 ? {9'd0, wr_reg} : 17'd0);
                accg_next = {accg_reg[10:0], 1'b0}
                            + (q1 ? {8'd0, lfcs_pkg::GREEN_WEIGHT} : 12'd0);
                accb_next = {accb_reg[17:0], 1'b0} + (q1 ? {9'd0, wb_reg} : 19'd0);
                if (cnt_reg == 4'd0) begin
                    remr_next  = {1'b0, accr_next[16:10]};
                    remg_next  = {2'b00, accg_next[11:10]};
                    remb_next  = accb_next[18:10];
                    cnt_next   = DIV2_LAST;
                    state_next = ST_DIV2;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_DIV2: begin
                // restoring division, quotient bits shift into the low accumulator bits
                remr_next       = qr ? 8'(trialr - lfcs_pkg::DIV_RED) : trialr[7:0];
                remg_next       = qg ? 4'(trialg - lfcs_pkg::DIV_GREEN) : trialg[3:0];
                remb_next       = qb ? 9'(trialb - lfcs_pkg::DIV_BLUE) : trialb[8:0];
                accr_next[9:0]  = {accr_reg[8:0], qr};
                accg_next[9:0]  = {accg_reg[8:0], qg};
                accb_next[9:0]  = {accb_reg[8:0], qb};
                if (cnt_reg == 4'd0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_DONE: begin
                // hand over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = {strip_reg, blue_sat, green_sat, red_sat};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 4'd0;
            level_reg     <= 8'd0;
            m_tvalid_reg  <= 1'b0;
            min_level_reg <= lfcs_pkg::MIN_LEVEL_RST;
            max_level_reg <= lfcs_pkg::MAX_LEVEL_RST;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            level_reg    <= level_next;
            m_tvalid_reg <= m_tvalid_next;
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    lfcs_pkg::REG_MIN_LEVEL: min_level_reg <= pwdata[7:0];
                    lfcs_pkg::REG_MAX_LEVEL: max_level_reg <= pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        f_reg        <= f_next;
        wr_reg       <= wr_next;
        wb_reg       <= wb_next;
        red_zero_reg <= red_zero_next;
        strip_reg    <= strip_next;
        accp_reg     <= accp_next;
        rem1_reg     <= rem1_next;
        num1_reg     <= num1_next;
        accr_reg     <= accr_next;
        accg_reg     <= accg_next;
        accb_reg     <= accb_next;
        remr_reg     <= remr_next;
        remg_reg     <= remg_next;
        remb_reg     <= remb_next;
        out_reg      <= out_next;
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign pready   = 1'b1;

    // register readback
    always_comb begin
        case (paddr[2])
            lfcs_pkg::REG_MIN_LEVEL: prdata = {24'd0, min_level_reg};
            lfcs_pkg::REG_MAX_LEVEL: prdata = {24'd0, max_level_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // an accepted pixel always starts the multiply
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL))
        else $error("accepted pixel did not start the multiply");

    // scale division remainder stays below its divisor
    a_rem1_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV1) |-> (rem1_reg < lfcs_pkg::DIV_SCALE[6:0]))
        else $error("scale remainder out of range");

    // channel remainders stay below their divisors
    a_rem2_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV2) |-> ((remr_reg < lfcs_pkg::DIV_RED[7:0])
                                    && (remg_reg < lfcs_pkg::DIV_GREEN[3:0])
                                    && (remb_reg < lfcs_pkg::DIV_BLUE[8:0])))
        else $error("channel remainder out of range");

    // a finished result is held while the output register is occupied
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result overwrote a pending output");

    // a new result only appears when the sequencer finishes
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("output valid without a finished pixel");

endmodule
